### sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, checked only out of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked invariant on any cycle with valid output.
`define ASSERT_ON_VALID(lbl, vld, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (vld |-> (cond))) \
		else $error(msg);

`endif

### sv/ffrc_pkg.sv
// ----------------------------------------------------------------------------
// ffrc_pkg
// Constants, status codes and the CRC-16 byte update for the fixed frame
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ffrc_pkg;

	localparam int FRAME_BYTES = 74;

	localparam int POS_W    = 7;
	localparam int STATUS_W = 3;
	localparam int TDATA_W  = 24;

	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  END_MARK  = 8'h03;
	localparam logic [7:0]  SIZE_MARK = 8'h48;
	localparam int          SIZE_POS  = 4;
	localparam int          HDR_BYTES = 3;

	localparam logic [STATUS_W-1:0] ST_IN_PROGRESS = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_HEADER  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_END     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_CRC     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_GOOD_FRAME  = 3'd5;

	function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h02;
			2'd1:    b = 8'h01;
			2'd2:    b = 8'hFE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// reflected CRC-16, one byte, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### sv/fixed_frame_receiver_crc16_core.sv
// ----------------------------------------------------------------------------
// fixed_frame_receiver_crc16_core
// Receives a byte stream, tracks fixed-length frames with a 02 01 FE header
// and reports each byte with its frame offset and a frame check status.
// ----------------------------------------------------------------------------
// channel   dir  payload (tdata, low bit first)
// s_axis    in   rx_byte[7:0]
// m_axis    out  data_byte[7:0], position[14:8], status[17:15], zero pad
//
// One word per cycle sustained while the output is not stalled; input register,
// then result register, with the CRC byte update between them.
// Reset clears frame position and both valid flags and presets the running CRC.
// A stalled output holds its word; the input register still accepts while
// the result register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_receiver_crc16_core
	import ffrc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic [7:0]         s_tdata,   // rx_byte[7:0]
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [TDATA_W-1:0] m_tdata    // data_byte, position, status, pad
);

	logic              v_s1;
	logic [7:0]        byte_s1;

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       crc_q;
	logic [7:0]        len_q;
	logic [15:0]       rcrc_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [STATUS_W-1:0] out_status_q;

	logic              adv;
	logic              hdr_bad;
	logic              in_crc;
	logic              is_last;
	logic [15:0]       crc_next;
	logic [STATUS_W-1:0] status;

	assign adv      = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;

	assign hdr_bad  = (pos_q < POS_W'(HDR_BYTES)) && (byte_s1 != hdr_byte(pos_q[1:0]));
	assign in_crc   = (pos_q >= POS_W'(1)) && (pos_q <= POS_W'(FRAME_BYTES - 4));
	assign is_last  = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign crc_next = crc_byte(crc_q, byte_s1);

	always_comb begin
		status = ST_IN_PROGRESS;
		if (hdr_bad) begin
			status = ST_BAD_HEADER;
		end else if (is_last) begin
			if (byte_s1 != END_MARK) begin
				status = ST_BAD_END;
			end else if (len_q != SIZE_MARK) begin
				status = ST_BAD_SIZE;
			end else if (rcrc_q != crc_q) begin
				status = ST_BAD_CRC;
			end else begin
				status = ST_GOOD_FRAME;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			len_q  <= '0;
			rcrc_q <= '0;
		end else if (adv) begin
			if (hdr_bad || is_last) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (in_crc) begin
					crc_q <= crc_next;
				end
			end
			if (!hdr_bad) begin
				if (pos_q == POS_W'(SIZE_POS)) begin
					len_q <= byte_s1;
				end
				if (pos_q == POS_W'(FRAME_BYTES - 3)) begin
					rcrc_q[7:0] <= byte_s1;
				end
				if (pos_q == POS_W'(FRAME_BYTES - 2)) begin
					rcrc_q[15:8] <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= byte_s1;
			out_pos_q    <= pos_q;
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - 8 - POS_W - STATUS_W){1'b0}},
		out_status_q, out_pos_q, out_byte_q};

endmodule

`default_nettype wire

### sv/ffrc_checker.sv
// ----------------------------------------------------------------------------
// ffrc_checker
// Port-level checks for the fixed frame receiver, bound to the receiver core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ffrc_checker
	import ffrc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata
);

	logic [POS_W-1:0]    pos;
	logic [STATUS_W-1:0] status;
	logic                in_hs;
	logic                hdr_st;
	logic                end_st;

	assign pos    = m_tdata[8 +: POS_W];
	assign status = m_tdata[8 + POS_W +: STATUS_W];
	assign in_hs  = s_tvalid && s_tready;
	assign hdr_st = (status == ST_BAD_HEADER);
	assign end_st = (status != ST_IN_PROGRESS) && !hdr_st;

	// a stalled output stays valid
	`ASSERT_CLKD(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")

	// after an accepted input word, output valid is checked once the word could pass both registers
	`ASSERT_CLKD(a_in_to_out, in_hs |-> ##2 m_tvalid, "accepted word did not reach output")

	`ASSERT_ON_VALID(a_pos_range, m_tvalid, pos <= POS_W'(FRAME_BYTES - 1), "position out of frame")

	`ASSERT_ON_VALID(a_hdr_pos, m_tvalid && hdr_st, pos < POS_W'(HDR_BYTES), "bad header past header")

	`ASSERT_ON_VALID(a_final_pos, m_tvalid && end_st, pos == POS_W'(FRAME_BYTES - 1), "early frame status")

endmodule

bind fixed_frame_receiver_crc16_core ffrc_checker u_ffrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
